FILE: hdl/bap_pkg.sv
`timescale 1ns / 1ps

package bap_pkg;

  // Default capacity of the block, handed to the top level parameters.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_BLOCK  = 16;

  // Field widths of the stream and register interfaces.
  localparam int PIX_W     = 8;
  localparam int NUM_CHAN  = 3;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 48;
  localparam int BLK_IDX_W = 11;
  localparam int BSIZE_W   = 5;
  localparam int FDIM_W    = 12;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Register reset values.
  localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE   = 5'd6;
  localparam logic [FDIM_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
  localparam logic [FDIM_W-1:0]  RST_FRAME_HEIGHT = 12'd480;

  // The quotient of a block average never exceeds one pixel value, so the
  // divider produces one bit per step over this many steps.
  localparam int DIV_STEPS   = PIX_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_BLOCK_SIZE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } bap_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a pixel, read its column sum, advance counters
    logic mul;       // form the replication weight
    logic prod;      // weight times pixel value
    logic acc;       // accumulate, write back, start the divider
    logic div_step;  // one restoring division step
    logic emit;      // load the output register
    logic restart;   // return the position counters to the frame start
  } bap_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close;     // the current pixel completes its block
    logic out_free;  // the output register can take a result this cycle
  } bap_stat_t;

endpackage

FILE: hdl/bap_ram.sv
`timescale 1ns / 1ps

module bap_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bap_ctrl.sv
`timescale 1ns / 1ps

module bap_ctrl
  import bap_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      cfg_write,
  input  bap_stat_t stat,
  output bap_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PROD,
    S_ACC,
    S_DIV,
    S_EMIT
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] div_cnt;

  // A new pixel is taken only between transactions of the datapath.
  assign s_tready = (state == S_IDLE);

  // Command decode.
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && s_tvalid;
    cmd.mul      = (state == S_MUL);
    cmd.prod     = (state == S_PROD);
    cmd.acc      = (state == S_ACC);
    cmd.div_step = (state == S_DIV);
    cmd.emit     = (state == S_EMIT) && stat.out_free;
    cmd.restart  = cfg_write;
  end

  // Sequencing of one pixel through the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_PROD;
        end
        S_PROD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          div_cnt <= '0;
          state   <= stat.close ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/bap_datapath.sv
`timescale 1ns / 1ps

module bap_datapath
  import bap_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bap_cmd_t              cmd,
  output bap_stat_t             stat,
  input  logic [BSIZE_W-1:0]    block_size,
  input  logic [FDIM_W-1:0]     frame_width,
  input  logic [FDIM_W-1:0]     frame_height,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_BLOCK);
  localparam int BW = $clog2(MAX_BLOCK + 1);
  localparam int MW = 2 * BW;
  localparam int SW = PIX_W + 2 * CW;

  // Effective configuration, with out-of-range values saturated.
  logic [BW-1:0] bs_c;
  logic [WW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic [XW-1:0] x_end;
  logic [YW-1:0] y_end;
  logic [CW-1:0] c_end;

  // Position state.
  logic [XW-1:0] pixel_x;
  logic [YW-1:0] pixel_y;
  logic [CW-1:0] col_in_block;
  logic [CW-1:0] row_in_block;
  logic [XW-1:0] bcol;
  logic [YW-1:0] brow;

  logic          last_x;
  logic          last_y;
  logic          close_x;
  logic          close_y;
  logic [BW-1:0] wx;
  logic [BW-1:0] wy;

  // Per-pixel work registers.
  logic [NUM_CHAN-1:0][PIX_W-1:0] px;
  logic [BW-1:0]                  wx_q;
  logic [BW-1:0]                  wy_q;
  logic [MW-1:0]                  wt;
  logic [MW-1:0]                  area;
  logic [NUM_CHAN-1:0][SW-1:0]    prod;
  logic [XW-1:0]                  bcol_q;
  logic [YW-1:0]                  brow_q;
  logic                           first_q;
  logic                           close_q;
  logic                           fend_q;

  // Column sum memory and divider.
  logic [NUM_CHAN-1:0][SW-1:0]    old_sum;
  logic [NUM_CHAN-1:0][SW-1:0]    new_sum;
  logic [NUM_CHAN-1:0][SW-1:0]    rem;
  logic [SW-1:0]                  dsh;
  logic [NUM_CHAN-1:0][PIX_W-1:0] quo;

  // Output register fields.
  logic [BLK_IDX_W-1:0]           out_col;
  logic [BLK_IDX_W-1:0]           out_row;
  logic [NUM_CHAN-1:0][PIX_W-1:0] out_avg;

  // Saturate the registers into their working ranges.
  always_comb begin
    if (block_size == '0) begin
      bs_c = BW'(1);
    end else if (32'(block_size) > MAX_BLOCK) begin
      bs_c = BW'(MAX_BLOCK);
    end else begin
      bs_c = BW'(block_size);
    end
    if (frame_width == '0) begin
      w_c = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_c = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(frame_height);
    end
    x_end = XW'(w_c - WW'(1));
    y_end = YW'(h_c - HW'(1));
    c_end = CW'(bs_c - BW'(1));
  end

  // Edge detection and replication weights for the current position.
  always_comb begin
    last_x  = (pixel_x == x_end);
    last_y  = (pixel_y == y_end);
    close_x = last_x || (col_in_block == c_end);
    close_y = last_y || (row_in_block == c_end);
    wx      = last_x ? BW'(bs_c - BW'(col_in_block)) : BW'(1);
    wy      = last_y ? BW'(bs_c - BW'(row_in_block)) : BW'(1);
  end

  // Raster position and block counters advance as each pixel is taken.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      pixel_x      <= '0;
      pixel_y      <= '0;
      col_in_block <= '0;
      row_in_block <= '0;
      bcol         <= '0;
      brow         <= '0;
    end else if (cmd.load) begin
      col_in_block <= close_x ? '0 : col_in_block + 1'b1;
      if (last_x) begin
        pixel_x <= '0;
        bcol    <= '0;
        if (last_y) begin
          pixel_y      <= '0;
          brow         <= '0;
          row_in_block <= '0;
        end else begin
          pixel_y      <= pixel_y + 1'b1;
          row_in_block <= close_y ? '0 : row_in_block + 1'b1;
          if (close_y) begin
            brow <= brow + 1'b1;
          end
        end
      end else begin
        pixel_x <= pixel_x + 1'b1;
        if (close_x) begin
          bcol <= bcol + 1'b1;
        end
      end
    end
  end

  // Capture the pixel and what its position says about it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px      <= s_tdata;
      wx_q    <= wx;
      wy_q    <= wy;
      bcol_q  <= bcol;
      brow_q  <= brow;
      first_q <= (col_in_block == '0) && (row_in_block == '0);
      close_q <= close_x && close_y;
      fend_q  <= last_x && last_y;
    end
  end

  // Block area for the divider; the registers are steady long before use.
  always_ff @(posedge clk) begin
    area <= MW'(bs_c * bs_c);
  end

  // Weight, then weighted pixel value, one multiplier stage each.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      wt <= MW'(wx_q * wy_q);
    end
    if (cmd.prod) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        prod[i] <= SW'(px[i] * wt);
      end
    end
  end

  // The first pixel of a block starts the sum, later ones add to it.
  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      new_sum[i] = prod[i] + (first_q ? SW'(0) : old_sum[i]);
    end
  end

  bap_ram #(
    .WIDTH (NUM_CHAN * SW),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (bcol_q),
    .wdata (new_sum),
    .re    (cmd.load),
    .raddr (bcol),
    .rdata (old_sum)
  );

  // Restoring division by the block area, one quotient bit per step.
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      rem <= new_sum;
      dsh <= SW'({area, 7'b0});
      quo <= '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        if (rem[i] >= dsh) begin
          rem[i] <= rem[i] - dsh;
          quo[i] <= {quo[i][PIX_W-2:0], 1'b1};
        end else begin
          quo[i] <= {quo[i][PIX_W-2:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
    end
  end

  // Output register holds a finished block until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_col <= BLK_IDX_W'(bcol_q);
      out_row <= BLK_IDX_W'(brow_q);
      out_avg <= quo;
      m_tlast <= fend_q;
    end
  end

  assign m_tdata = {2'b00, out_avg, out_row, out_col};

  assign stat.close    = close_q;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

FILE: hdl/block_average_pixelate_top.sv
`timescale 1ns / 1ps

// Block-average mosaic. Three-channel 8-bit pixels enter in raster order over
// a frame of frame_width by frame_height pixels and are summed per channel
// over square blocks of block_size pixels; each block yields one transaction
// carrying its column and row index and the truncated channel averages, with
// tlast on the last block of the frame. Blocks cut by the right or bottom
// edge are completed by replicating the last column and row. A pixel that
// does not finish a block goes through a weight multiply, a product stage
// and the read-modify-write of the column sum memory; a pixel that finishes
// a block goes on through the bit-serial divider (one quotient bit per
// cycle) and the load of the output register, which waits while a previous
// result is held there for m_tready. Once loaded, a result waiting in the
// output register does not hold back the next pixel. A write to a defined
// register restarts the frame at its first pixel.
module block_average_pixelate_top
  import bap_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst,
  // Pixel stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // chan_a, chan_b, chan_c
  // Block average stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // block_col, block_row, avg_a, avg_b, avg_c
  output logic                  m_tlast,   // frame_end
  // Register port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [BSIZE_W-1:0] block_size;
  logic [FDIM_W-1:0]  frame_width;
  logic [FDIM_W-1:0]  frame_height;
  logic               wr_en;
  logic               cfg_write;
  bap_cmd_t           cmd;
  bap_stat_t          stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; a write to a defined register restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= RST_BLOCK_SIZE;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_BLOCK_SIZE:   block_size   <= pwdata[BSIZE_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FDIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FDIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BLOCK_SIZE, REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_write = wr_en;
      default: cfg_write = 1'b0;
    endcase
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      REG_BLOCK_SIZE:   prdata = APB_DATA_W'(block_size);
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  bap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_write (cfg_write),
    .stat      (stat),
    .cmd       (cmd)
  );

  bap_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .block_size   (block_size),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

`ifndef SYNTH
  // A pixel is followed by its datapath work before the next one is taken.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("pixel input taken while the previous pixel is in flight");

  // A new result appears only from the emit step, when input is held off.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result loaded outside the emit step");

  // Each emit follows the division, so input is not ready while emitting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !s_tready && !cmd.load)
    else $error("emit overlaps a pixel transaction");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bap_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 11;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYC  = 24;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_PIX  = 750;
  localparam int MAX_W       = DEF_MAX_WIDTH;
  localparam int MAX_H       = DEF_MAX_HEIGHT;
  localparam int MAX_BLK     = DEF_MAX_BLOCK;

  // Register index past the end of the register list; writes to it are dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // One finished block, laid out as {m_tlast, m_tdata[45:0]}.
  typedef struct packed {
    logic                 frame_end;
    logic [PIX_W-1:0]     avg_c;
    logic [PIX_W-1:0]     avg_b;
    logic [PIX_W-1:0]     avg_a;
    logic [BLK_IDX_W-1:0] block_row;
    logic [BLK_IDX_W-1:0] block_col;
  } block_avg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // chan_a, chan_b, chan_c
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // block_col, block_row, avg_a, avg_b, avg_c
  logic                  m_tlast;        // frame_end
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Pixels waiting to be sent and block averages waiting to arrive.
  logic [IN_DATA_W-1:0] pix_queue [$];
  block_avg_t           avg_expect [$];

  int pushed_cnt   = 0;
  int offered_cnt  = 0;
  int accepted_cnt = 0;
  int fail_cnt     = 0;
  int cycle_cnt    = 0;
  int random_pix   = 0;

  // Long receiver hold-off: requested by the stimulus, run by the receiver.
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int tx_gap = 0;
  int tx_calm = 0;
  int rx_stall = 0;
  int rx_calm = 0;

  // Mirror of the block: registers, position counters and column sums.
  logic [BSIZE_W-1:0] cfg_bsize;
  logic [FDIM_W-1:0]  cfg_width;
  logic [FDIM_W-1:0]  cfg_height;
  int unsigned        pos_x, pos_y, row_blk, col_blk;
  int unsigned        col_sum [MAX_W][NUM_CHAN];

  block_average_pixelate_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout at %0t after %0d cycles", $time, cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_pos();
    pos_x = 0;
    pos_y = 0;
    row_blk = 0;
    col_blk = 0;
  endfunction

  // Register write as the block sees it; only listed registers restart the frame.
  function automatic void apply_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
    if (idx == REG_BLOCK_SIZE) cfg_bsize = val[BSIZE_W-1:0];
    else if (idx == REG_FRAME_WIDTH) cfg_width = val[FDIM_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) cfg_height = val[FDIM_W-1:0];
    else return;
    restart_pos();
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_value(input logic [1:0] idx);
    if (idx == REG_BLOCK_SIZE) return APB_DATA_W'(cfg_bsize);
    if (idx == REG_FRAME_WIDTH) return APB_DATA_W'(cfg_width);
    return APB_DATA_W'(cfg_height);
  endfunction

  // Accumulate one pixel into its block column and queue the block average
  // when this pixel closes the block. Pixels on the last column or row carry
  // the weight of the replicated pixels that fill the rest of the block.
  function automatic void predict_block(input logic [IN_DATA_W-1:0] pix);
    int unsigned bs, w, h, wx, wy, bcol, brow, area;
    logic        last_x, last_y, close_x, close_y;
    block_avg_t  r;
    bs = clamp_dim(cfg_bsize, MAX_BLK);
    w  = clamp_dim(cfg_width, MAX_W);
    h  = clamp_dim(cfg_height, MAX_H);
    if (pos_x >= w || pos_y >= h || col_blk >= bs || row_blk >= bs) restart_pos();
    last_x = (pos_x == w - 1);
    last_y = (pos_y == h - 1);
    wx = last_x ? bs - col_blk : 1;
    wy = last_y ? bs - row_blk : 1;
    bcol = (pos_x / bs) % MAX_W;
    brow = pos_y / bs;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (row_blk == 0 && col_blk == 0) col_sum[bcol][c] = pix[PIX_W*c +: PIX_W] * wx * wy;
      else col_sum[bcol][c] += pix[PIX_W*c +: PIX_W] * wx * wy;
    end
    close_x = last_x || (col_blk == bs - 1);
    close_y = last_y || (row_blk == bs - 1);
    if (close_x && close_y) begin
      area = bs * bs;
      r.block_col = bcol[BLK_IDX_W-1:0];
      r.block_row = brow[BLK_IDX_W-1:0];
      r.avg_a = PIX_W'(col_sum[bcol][0] / area);
      r.avg_b = PIX_W'(col_sum[bcol][1] / area);
      r.avg_c = PIX_W'(col_sum[bcol][2] / area);
      r.frame_end = last_x && last_y;
      avg_expect.push_back(r);
    end
    // Step to the next pixel position.
    if (close_x) col_blk = 0;
    else col_blk++;
    if (last_x) begin
      pos_x = 0;
      if (close_y) row_blk = 0;
      else row_blk++;
      if (last_y) begin
        pos_y = 0;
        row_blk = 0;
      end else begin
        pos_y++;
      end
    end else begin
      pos_x++;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 15);
    return $urandom_range(20, 60);
  endfunction

  // Pixel driver, fed from pix_queue.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && accepted_cnt != offered_cnt) begin
      // The current pixel has not been taken yet.
    end else if (tx_gap > 0) begin
      tx_gap--;
      s_tvalid <= 1'b0;
    end else if (pix_queue.size() > 0) begin
      s_tdata  <= pix_queue.pop_front();
      s_tvalid <= 1'b1;
      offered_cnt++;
      if (tx_calm > 0) begin
        tx_calm--;
        tx_gap = 0;
      end else if ($urandom_range(0, 99) == 0) begin
        tx_calm = $urandom_range(50, 200);
        tx_gap = 0;
      end else if ($urandom_range(0, 2) == 0) begin
        tx_gap = pick_gap();
      end else begin
        tx_gap = 0;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Each accepted pixel transaction goes through the predictor.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_block(s_tdata);
      accepted_cnt++;
    end
  end

  // Receiver back pressure, including the one long hold-off.
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else begin
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 99) == 0) rx_calm = $urandom_range(50, 200);
      else if ($urandom_range(0, 2) == 0) rx_stall = pick_gap();
      m_tready <= (rx_stall == 0);
    end
  end

  // Compare each block average transaction with the oldest expectation.
  always @(posedge clk) begin : watch
    block_avg_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata[45:0]};
      if (avg_expect.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected block average col %0d row %0d", $time,
                 got.block_col, got.block_row);
      end else begin
        want = avg_expect.pop_front();
        check_field("block_col", want.block_col, got.block_col);
        check_field("block_row", want.block_row, got.block_row);
        check_field("avg_a", want.avg_a, got.avg_a);
        check_field("avg_b", want.avg_b, got.avg_b);
        check_field("avg_c", want.avg_c, got.avg_c);
        check_field("frame_end", want.frame_end, got.frame_end);
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(input logic [1:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", reg_value(idx), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_pixel(input logic [IN_DATA_W-1:0] pix);
    pix_queue.push_back(pix);
    pushed_cnt++;
  endtask

  task automatic push_random(input int n);
    repeat (n) push_pixel(IN_DATA_W'($urandom()));
  endtask

  // Wait until every pixel is taken and every block average has arrived.
  task automatic wait_drained();
    while (pushed_cnt != accepted_cnt || avg_expect.size() != 0) @(posedge clk);
  endtask

  // Program a frame once the block is idle. Writes go in a random order and
  // sometimes carry junk above the register width.
  task automatic set_frame(input int bs, input int w, input int h);
    logic [APB_DATA_W-1:0] vals [3];
    int start;
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    vals[0] = bs;
    vals[1] = w;
    vals[2] = h;
    start = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        vals[(start + k) % 3][APB_DATA_W-1:FDIM_W] = $urandom();
        if ((start + k) % 3 == 0) vals[0][FDIM_W-1:BSIZE_W] = $urandom();
      end
      reg_write(2'((start + k) % 3), vals[(start + k) % 3]);
    end
    reg_check(2'($urandom_range(0, 2)));
  endtask

  task automatic random_phase();
    int mode, bs, w, h, frame, n, part;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      // Width at or past the largest frame, only partly sent.
      w  = ($urandom_range(0, 1) == 0) ? 4095 : $urandom_range(MAX_W, 4095);
      h  = $urandom_range(0, 2);
      bs = $urandom_range(8, 16);
      n  = $urandom_range(32, 80);
    end else if (mode == 1) begin
      w  = $urandom_range(0, 3);
      h  = ($urandom_range(0, 1) == 0) ? 4095 : MAX_H;
      bs = $urandom_range(1, 4);
      n  = $urandom_range(30, 80);
    end else begin
      if ($urandom_range(0, 14) == 0) bs = $urandom_range(17, 31);
      else if ($urandom_range(0, 14) == 0) bs = 0;
      else if ($urandom_range(0, 7) == 0) bs = $urandom_range(9, 16);
      else bs = $urandom_range(1, 8);
      w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
      h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
      frame = clamp_dim(w, MAX_W) * clamp_dim(h, MAX_H);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, frame);
      else n = frame * $urandom_range(1, 2);
      if (n > 200) n = 200;
    end
    set_frame(bs, w, h);
    if ($urandom_range(0, 7) == 0) begin
      reg_write(REG_SPARE, $urandom());
      reg_check(2'($urandom_range(0, 2)));
    end
    // Sometimes the sender stops part way until all results are in.
    if (n > 1 && $urandom_range(0, 3) == 0) begin
      part = $urandom_range(1, n - 1);
      push_random(part);
      wait_drained();
      push_random(n - part);
    end else begin
      push_random(n);
    end
    random_pix += n;
  endtask

  initial begin
    cfg_bsize  = RST_BLOCK_SIZE;
    cfg_width  = RST_FRAME_WIDTH;
    cfg_height = RST_FRAME_HEIGHT;
    restart_pos();
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values of the registers.
    reg_check(REG_BLOCK_SIZE);
    reg_check(REG_FRAME_WIDTH);
    reg_check(REG_FRAME_HEIGHT);

    // Single-pixel frames: every pixel is its own block and frame.
    set_frame(1, 1, 1);
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'hA55AC3);
    push_pixel(24'h5AA53C);

    // Zero block size and frame dimensions act as one.
    set_frame(0, 0, 0);
    push_pixel(24'h0F1E2D);
    push_pixel(24'hF0E1D2);

    // Oversized block, saturated to the maximum and larger than the frame.
    set_frame(31, 3, 2);
    push_random(6);

    // Edge blocks on both sides, with a write past the register list mid-frame
    // that must leave the frame position alone.
    set_frame(2, 3, 3);
    push_random(4);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    reg_write(REG_SPARE, $urandom());
    push_random(5);

    // One result per pixel while the receiver holds off for a long stretch.
    set_frame(1, 8, 8);
    hold_go <= 1'b1;
    push_random(64);
    random_pix += 64;

    // Saturated width and saturated height.
    set_frame(16, 4095, 1);
    push_random(48);
    set_frame(2, 1, 4095);
    push_random(40);
    random_pix += 88;

    while (random_pix < RANDOM_PIX) random_phase();

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
